// ===== hw/rtl/mfde_pkg.sv =====
// mfde_pkg: transaction types, command codes and queue entry type for the
// monochrome frame draw engine; no dependencies
package mfde_pkg;

  localparam logic [1:0] CMD_PLOT   = 2'd0;
  localparam logic [1:0] CMD_LINE   = 2'd1;
  localparam logic [1:0] CMD_CIRCLE = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] x_start;
    logic [5:0] y_start;
    logic [6:0] x_end;
    logic [5:0] y_end;
    logic [5:0] radius;
    logic       color;
    logic [2:0] read_page;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       pixels_dropped;
  } out_item_t;

  typedef struct packed {
    in_item_t           item;
    logic [6:0]         delta_x;
    logic [6:0]         delta_y;
    logic signed [1:0]  step_x;
    logic signed [1:0]  step_y;
    logic [6:0]         span;
    logic               read_ok;
  } cmd_entry_t;

endpackage

// ===== hw/rtl/mfde_front.sv =====
// mfde_front: accepts input transactions, precomputes line setup and read
// address check, and holds them in a two-entry queue; uses mfde_pkg
module mfde_front #(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mfde_pkg::in_item_t    in_data,
  output logic                  q_valid,
  output mfde_pkg::cmd_entry_t  q_entry,
  input  logic                  q_pop
);

  mfde_pkg::cmd_entry_t queue_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  mfde_pkg::cmd_entry_t entry;
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic push;
  logic pop;

  always_comb begin
    dx = $signed({1'b0, in_data.x_end}) - $signed({1'b0, in_data.x_start});
    dy = $signed({2'b0, in_data.y_end}) - $signed({2'b0, in_data.y_start});
    entry.item    = in_data;
    entry.delta_x = dx[7] ? 7'(-dx) : dx[6:0];
    entry.delta_y = dy[7] ? 7'(-dy) : dy[6:0];
    entry.step_x  = dx[7] ? -2'sd1 : ((dx == 8'sd0) ? 2'sd0 : 2'sd1);
    entry.step_y  = dy[7] ? -2'sd1 : ((dy == 8'sd0) ? 2'sd0 : 2'sd1);
    entry.span    = (entry.delta_x > entry.delta_y) ? entry.delta_x : entry.delta_y;
    entry.read_ok = (int'(in_data.x_end) < PANEL_COLUMNS) &&
                    (int'(in_data.read_page) < PANEL_PAGES);
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = queue_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/mfde_back.sv =====
// mfde_back: executes queued commands against the frame store with
// read-modify-write pixel access and holds the result register; uses mfde_pkg
module mfde_back #(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  mfde_pkg::cmd_entry_t  q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mfde_pkg::out_item_t   out_data
);

  localparam int DEPTH  = PANEL_COLUMNS * PANEL_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROWS   = PANEL_PAGES * 8;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LINE, S_CCHK, S_CPIX, S_CSTEP, S_PADDR, S_PWR, S_RDATA, S_DONE
  } state_t;

  logic [7:0]        frame_store [DEPTH];
  logic [7:0]        mem_q_r;
  state_t            state_r;
  state_t            ret_r;
  logic [ADDR_W:0]   clr_cnt_r;
  logic signed [9:0] px_r;
  logic signed [9:0] py_r;
  logic              set_r;
  logic              drop_r;
  logic [7:0]        byte_r;
  logic [ADDR_W-1:0] addr_r;
  logic signed [9:0] cx_r;
  logic signed [9:0] cy_r;
  logic [7:0]        ex_r;
  logic [7:0]        ey_r;
  logic [6:0]        n_r;
  logic [6:0]        dxm_r;
  logic [6:0]        dym_r;
  logic signed [1:0] sx_r;
  logic signed [1:0] sy_r;
  logic [6:0]        dist_r;
  logic [6:0]        a_r;
  logic [6:0]        b_r;
  logic [11:0]       r2_r;
  logic [2:0]        k_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  mfde_pkg::out_item_t out_data_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [7:0]        bit_mask;
  logic [7:0]        ex_sum;
  logic [7:0]        ey_sum;
  logic signed [9:0] ox;
  logic signed [9:0] oy;
  logic signed [9:0] sa;
  logic signed [9:0] sb;
  logic [13:0]       b_sq2;
  logic [6:0]        a_inc;
  logic [13:0]       circ_sum;

  always_comb begin
    pix_ok   = (px_r >= 10'sd0) && (int'(px_r) < PANEL_COLUMNS) &&
               (py_r >= 10'sd0) && (int'(py_r) < ROWS);
    pix_addr = ADDR_W'(int'(px_r[8:0]) * PANEL_PAGES + int'(py_r[8:3]));
    read_addr = ADDR_W'(int'(q_entry.item.x_end) * PANEL_PAGES +
                        int'(q_entry.item.read_page));
    bit_mask = 8'(1) << py_r[2:0];
    ex_sum   = ex_r + 8'(dxm_r);
    ey_sum   = ey_r + 8'(dym_r);
    sa       = $signed({3'b0, a_r});
    sb       = $signed({3'b0, b_r});
    b_sq2    = 14'({b_r, 1'b0} * b_r);
    a_inc    = a_r + 7'd1;
    circ_sum = 14'(a_inc * a_inc) + 14'(b_r * b_r);
    case (k_r)
      3'd0:    begin ox = sa;  oy = -sb; end
      3'd1:    begin ox = -sa; oy = -sb; end
      3'd2:    begin ox = -sa; oy = sb;  end
      3'd3:    begin ox = sa;  oy = sb;  end
      3'd4:    begin ox = sb;  oy = sa;  end
      3'd5:    begin ox = sb;  oy = -sa; end
      3'd6:    begin ox = -sb; oy = -sa; end
      default: begin ox = -sb; oy = sa;  end
    endcase
    q_pop   = (state_r == S_IDLE) && q_valid;
    rd_en   = 1'b0;
    rd_addr = pix_addr;
    if (q_pop && (q_entry.item.command == mfde_pkg::CMD_READ) && q_entry.read_ok) begin
      rd_en   = 1'b1;
      rd_addr = read_addr;
    end else if ((state_r == S_PADDR) && pix_ok) begin
      rd_en = 1'b1;
    end
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = set_r ? (mem_q_r | bit_mask) : (mem_q_r & ~bit_mask);
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[ADDR_W-1:0];
      wr_data = 8'd0;
    end else if (state_r == S_PWR) begin
      wr_en = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= frame_store[rd_addr];
    end
    if (wr_en) begin
      frame_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_IDLE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (int'(clr_cnt_r) == DEPTH - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            drop_r <= (q_entry.item.command == mfde_pkg::CMD_READ) && !q_entry.read_ok;
            byte_r <= 8'd0;
            set_r  <= (q_entry.item.command == mfde_pkg::CMD_CIRCLE) || q_entry.item.color;
            case (q_entry.item.command)
              mfde_pkg::CMD_PLOT: begin
                px_r    <= $signed({3'b0, q_entry.item.x_start});
                py_r    <= $signed({4'b0, q_entry.item.y_start});
                ret_r   <= S_DONE;
                state_r <= S_PADDR;
              end
              mfde_pkg::CMD_LINE: begin
                cx_r    <= $signed({3'b0, q_entry.item.x_start});
                cy_r    <= $signed({4'b0, q_entry.item.y_start});
                ex_r    <= 8'd0;
                ey_r    <= 8'd0;
                n_r     <= 7'd0;
                dxm_r   <= q_entry.delta_x;
                dym_r   <= q_entry.delta_y;
                sx_r    <= q_entry.step_x;
                sy_r    <= q_entry.step_y;
                dist_r  <= q_entry.span;
                state_r <= S_LINE;
              end
              mfde_pkg::CMD_CIRCLE: begin
                px_r  <= $signed({3'b0, q_entry.item.x_start});
                py_r  <= $signed({4'b0, q_entry.item.y_start});
                cx_r  <= $signed({3'b0, q_entry.item.x_start});
                cy_r  <= $signed({4'b0, q_entry.item.y_start});
                a_r   <= 7'd0;
                b_r   <= {1'b0, q_entry.item.radius};
                r2_r  <= 12'(q_entry.item.radius * q_entry.item.radius);
                if (q_entry.item.radius == 6'd0) begin
                  ret_r   <= S_DONE;
                  state_r <= S_PADDR;
                end else begin
                  state_r <= S_CCHK;
                end
              end
              default: begin
                if (q_entry.read_ok) begin
                  state_r <= S_RDATA;
                end else begin
                  state_r <= S_DONE;
                end
              end
            endcase
          end
        end
        S_LINE: begin
          px_r <= cx_r;
          py_r <= cy_r;
          if (ex_sum > 8'(dist_r)) begin
            ex_r <= ex_sum - 8'(dist_r);
            cx_r <= cx_r + 10'(sx_r);
          end else begin
            ex_r <= ex_sum;
          end
          if (ey_sum > 8'(dist_r)) begin
            ey_r <= ey_sum - 8'(dist_r);
            cy_r <= cy_r + 10'(sy_r);
          end else begin
            ey_r <= ey_sum;
          end
          n_r     <= n_r + 7'd1;
          ret_r   <= (n_r == dist_r) ? S_DONE : S_LINE;
          state_r <= S_PADDR;
        end
        S_CCHK: begin
          k_r     <= 3'd0;
          state_r <= (b_sq2 >= 14'(r2_r)) ? S_CPIX : S_DONE;
        end
        S_CPIX: begin
          px_r    <= cx_r + ox;
          py_r    <= cy_r + oy;
          k_r     <= k_r + 3'd1;
          ret_r   <= (k_r == 3'd7) ? S_CSTEP : S_CPIX;
          state_r <= S_PADDR;
        end
        S_CSTEP: begin
          if (circ_sum > 14'(r2_r)) begin
            b_r <= b_r - 7'd1;
          end else begin
            a_r <= a_inc;
          end
          state_r <= S_CCHK;
        end
        S_PADDR: begin
          addr_r <= pix_addr;
          if (pix_ok) begin
            state_r <= S_PWR;
          end else begin
            drop_r  <= 1'b1;
            state_r <= ret_r;
          end
        end
        S_PWR: begin
          state_r <= ret_r;
        end
        S_RDATA: begin
          byte_r  <= mem_q_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.pixel_byte     <= byte_r;
            out_data_r.pixels_dropped <= drop_r;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/monochrome_frame_draw_engine.sv =====
// monochrome_frame_draw_engine: top level, front queue plus drawing back end
// depends on mfde_pkg, mfde_front, mfde_back
//
// usage
//   in_valid/in_ready/in_data carry one command transaction (plot, line,
//   circle, byte read); out_valid/out_ready/out_data return exactly one
//   result transaction per command, in order
//   back end: one command at a time; each pixel is a read-modify-write of
//   the frame store, which has one read and one write port: the address is
//   registered and the byte read in S_PADDR, then written back in S_PWR;
//   line pixels and circle walk pixels are first placed in S_LINE or S_CPIX,
//   and each circle walk step adds the states S_CSTEP and S_CCHK
//   a two-entry queue takes new commands while the back end works, and the
//   back end parks a result in the output register and goes on to the next
//   queued command; it only waits if a second result is ready while the
//   first is still not taken
//   reset: the frame store is cleared by a pass over all PANEL_COLUMNS*PANEL_PAGES
//   bytes (1024 by default); commands are queued but not run until it ends
module monochrome_frame_draw_engine #(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mfde_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mfde_pkg::out_item_t  out_data
);

  logic                 q_valid;
  logic                 q_pop;
  mfde_pkg::cmd_entry_t q_entry;

  mfde_front #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_PAGES  (PANEL_PAGES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  mfde_back #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_PAGES  (PANEL_PAGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for monochrome_frame_draw_engine
// drives plot, line, circle and read transactions and checks each result
// against a frame model kept here; depends on mfde_pkg and the top level
`timescale 1ns / 100ps

module testbench;

  localparam int COLS = 128;
  localparam int PAGES = 8;
  localparam int ROWS = PAGES * 8;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mfde_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfde_pkg::out_item_t out_data;

  monochrome_frame_draw_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  logic [7:0] frame [COLS*PAGES];
  logic hit_dropped;
  mfde_pkg::out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int lines_sent = 0, circles_sent = 0, reads_sent = 0, plots_sent = 0;
  bit rx_idle_ok = 1'b1;
  bit hold_rx = 1'b0;

  function automatic void put_dot(int x, int y, bit set);
    int idx;
    if (x < 0 || x >= COLS || y < 0 || y >= ROWS) begin
      hit_dropped = 1'b1;
      return;
    end
    idx = x * PAGES + (y >> 3);
    frame[idx][y & 7] = set;
  endfunction

  function automatic mfde_pkg::out_item_t draw_predict(mfde_pkg::in_item_t c);
    mfde_pkg::out_item_t r;
    int dx, dy, sx, sy, span, ex, ey, cx, cy, a, b, rr, x, y;
    r = '0;
    hit_dropped = 1'b0;
    case (c.command)
      mfde_pkg::CMD_PLOT: put_dot(c.x_start, c.y_start, c.color);
      mfde_pkg::CMD_LINE: begin
        dx = int'(c.x_end) - int'(c.x_start);
        dy = int'(c.y_end) - int'(c.y_start);
        sx = (dx > 0) ? 1 : (dx == 0 ? 0 : -1);
        sy = (dy > 0) ? 1 : (dy == 0 ? 0 : -1);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx > dy) ? dx : dy;
        ex = 0; ey = 0; cx = c.x_start; cy = c.y_start;
        for (int n = 0; n <= span; n++) begin
          put_dot(cx, cy, c.color);
          ex += dx; ey += dy;
          if (ex > span) begin ex -= span; cx += sx; end
          if (ey > span) begin ey -= span; cy += sy; end
        end
      end
      mfde_pkg::CMD_CIRCLE: begin
        x = c.x_start; y = c.y_start; rr = c.radius;
        if (rr == 0) put_dot(x, y, 1'b1);
        else begin
          a = 0; b = rr;
          while (2 * b * b >= rr * rr) begin
            put_dot(x + a, y - b, 1'b1); put_dot(x - a, y - b, 1'b1);
            put_dot(x - a, y + b, 1'b1); put_dot(x + a, y + b, 1'b1);
            put_dot(x + b, y + a, 1'b1); put_dot(x + b, y - a, 1'b1);
            put_dot(x - b, y - a, 1'b1); put_dot(x - b, y + a, 1'b1);
            a++;
            if (a * a + b * b - rr * rr > 0) begin b--; a--; end
          end
        end
      end
      default: begin
        if (c.x_end < COLS && c.read_page < PAGES)
          r.pixel_byte = frame[c.x_end * PAGES + c.read_page];
        else hit_dropped = 1'b1;
      end
    endcase
    r.pixels_dropped = hit_dropped;
    return r;
  endfunction

  function automatic mfde_pkg::in_item_t make_cmd(logic [1:0] cmd, int xs, int ys, int xe,
                                                  int ye, int rad, bit col, int pg);
    mfde_pkg::in_item_t c;
    c.command = cmd; c.x_start = 7'(xs); c.y_start = 6'(ys); c.x_end = 7'(xe);
    c.y_end = 6'(ye); c.radius = 6'(rad); c.color = col; c.read_page = 3'(pg);
    return c;
  endfunction

  function automatic mfde_pkg::in_item_t random_cmd();
    mfde_pkg::in_item_t c;
    logic [63:0] raw;
    int pick;
    raw = {$urandom, $urandom};
    c = raw[$bits(mfde_pkg::in_item_t)-1:0];
    pick = $urandom_range(0, 9);
    if (pick < 3) c.command = mfde_pkg::CMD_PLOT;
    else if (pick < 5) c.command = mfde_pkg::CMD_LINE;
    else if (pick < 6) c.command = mfde_pkg::CMD_CIRCLE;
    else c.command = mfde_pkg::CMD_READ;
    if (c.command == mfde_pkg::CMD_CIRCLE && $urandom_range(0, 3) != 0)
      c.radius = 6'($urandom_range(0, 12));
    return c;
  endfunction

  // stimulus table: command, expected result where obvious
  typedef struct {
    mfde_pkg::in_item_t cmd;
    bit has_fixed;
    mfde_pkg::out_item_t fixed;
  } table_row_t;
  table_row_t directed [$];

  task automatic send_item(mfde_pkg::in_item_t c, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(draw_predict(c));
    case (c.command)
      mfde_pkg::CMD_PLOT: plots_sent++;
      mfde_pkg::CMD_LINE: lines_sent++;
      mfde_pkg::CMD_CIRCLE: circles_sent++;
      default: reads_sent++;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
  endtask

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        mfde_pkg::out_item_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.pixel_byte !== want.pixel_byte) begin
            $display("%0t: pixel_byte expected %h actual %h", $time,
                     want.pixel_byte, out_data.pixel_byte);
            errors++;
          end
          if (out_data.pixels_dropped !== want.pixels_dropped) begin
            $display("%0t: pixels_dropped expected %b actual %b", $time,
                     want.pixels_dropped, out_data.pixels_dropped);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) out_ready <= 1'b0;
      else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (rx_idle_ok && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    mfde_pkg::in_item_t c;
    for (int i = 0; i < COLS * PAGES; i++) frame[i] = 8'h00;
    // reset: end bytes read zero; then plots read back at both corners, then an erase
    directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{8'h00, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 127, 63, 127, 63, 63, 1, 7), 1,
                         '{8'h00, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_PLOT, 0, 0, 0, 0, 0, 1, 0), 1,
                         '{8'h00, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 5, 5, 0, 0, 0, 0, 0), 1,
                         '{8'h01, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_PLOT, 127, 63, 0, 0, 0, 1, 0), 1,
                         '{8'h00, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 0, 0, 127, 0, 0, 0, 7), 1,
                         '{8'h80, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_PLOT, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{8'h00, 1'b0}});
    directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{8'h00, 1'b0}});
    // lines: flat, steep, falling rows, full diagonal, point, flat erase
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 0, 10, 127, 10, 0, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 64, 0, 64, 63, 0, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 10, 60, 100, 3, 0, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 127, 0, 0, 63, 0, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 30, 30, 30, 30, 0, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_LINE, 0, 10, 127, 10, 0, 0, 0), 0, '0});
    // circles: zero radius, on panel, off-panel edges, largest; then reads
    directed.push_back('{make_cmd(mfde_pkg::CMD_CIRCLE, 40, 20, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_CIRCLE, 64, 32, 0, 0, 10, 0, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_CIRCLE, 0, 0, 0, 0, 5, 1, 0), 0, '0});
    directed.push_back('{make_cmd(mfde_pkg::CMD_CIRCLE, 127, 63, 0, 0, 63, 1, 0), 0, '0});
    for (int i = 0; i < 6; i++)
      directed.push_back('{make_cmd(mfde_pkg::CMD_READ, 0, 0, 64 + i, 0, 0, 0, i), 0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].has_fixed) begin
        mfde_pkg::out_item_t p;
        p = draw_predict(directed[i].cmd);
        // the local model must agree with the hand values
        if (p !== directed[i].fixed) begin
          $display("%0t: table row %0d expected %p predicted %p", $time, i,
                   directed[i].fixed, p);
          errors++;
        end
      end
    end
    // rewind the frame model, then replay the table through the block
    for (int i = 0; i < COLS * PAGES; i++) frame[i] = 8'h00;
    foreach (directed[i]) send_item(directed[i].cmd, 1'b1);
    drain_results();

    // long receiver hold-off so the queue fills and stalls the input
    hold_rx = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
        c = random_cmd();
        c.command = (i % 2) ? mfde_pkg::CMD_READ : mfde_pkg::CMD_PLOT;
        send_item(c, 1'b0);
      end
    join
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i >= RANDOM_ITEMS - 60) rx_idle_ok = 1'b0;
      send_item(random_cmd(), i < RANDOM_ITEMS - 60);
    end
    drain_results();
    repeat (3000) @(posedge clk);

    $display("covered %0d plots, %0d lines, %0d circles, %0d reads; %0d results checked",
             plots_sent, lines_sent, circles_sent, reads_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mfde_pkg.sv
hw/rtl/mfde_front.sv
hw/rtl/mfde_back.sv
hw/rtl/monochrome_frame_draw_engine.sv
tb/testbench.sv
